// File: rtl/edd_pkg.sv
// edd_pkg: shared constants, types and arithmetic helpers for the error diffusion dither
// no dependencies; compile before every other rtl file
`default_nettype none

package edd_pkg;

    // sizing
    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int ERROR_BITS    = 12;
    localparam int COL_BITS      = $clog2(MAX_WIDTH);
    localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
    localparam int VAL_BITS      = ERROR_BITS + 2;
    localparam int CH_BITS       = 8;
    localparam int SUM_BITS      = 10;
    localparam int THR_BITS      = 8;
    localparam int CFG_W_BITS    = 11;
    localparam int CFG_H_BITS    = 13;
    localparam int CFG_DATA_BITS = 13;
    localparam int CFG_IDX_BITS  = 2;

    // divide by three as multiply by reciprocal, exact for sums up to 765
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int PROD_BITS  = SUM_BITS + DIV3_SHIFT;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WHITE_THRESHOLD = 2'd2;

    // register reset values
    localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = 13'd1024;
    localparam logic [THR_BITS-1:0]   THR_RESET    = 8'd128;

    // diffusion weights in sixteenths
    localparam logic [2:0] WEIGHT_RIGHT      = 3'd7;
    localparam logic [2:0] WEIGHT_BELOW_LEFT = 3'd3;
    localparam logic [2:0] WEIGHT_BELOW      = 3'd5;
    localparam logic [2:0] WEIGHT_BELOW_RGT  = 3'd1;

    typedef logic signed [ERROR_BITS-1:0] t_err;
    typedef logic signed [VAL_BITS-1:0]   t_val;

    localparam t_val WHITE_LEVEL = VAL_BITS'(255);
    localparam t_val ERR_HI      = VAL_BITS'((1 << (ERROR_BITS - 1)) - 1);
    localparam t_val ERR_LO      = -ERR_HI - VAL_BITS'(1);

    typedef struct packed {
        logic [CH_BITS-1:0]  gray;
        logic [THR_BITS-1:0] threshold;
        t_err                right;
        t_err                below;
        t_err                pend_below;
        t_err                pend_below_left;
        logic                last_col;
    } t_diff_in;

    typedef struct packed {
        logic white;
        t_err row_write;
        t_err tail;
        t_err pend_below_left;
        t_err pend_below;
        t_err right;
    } t_diff_out;

    function automatic t_val ext_err(input t_err e);
        return {{(VAL_BITS - ERROR_BITS){e[ERROR_BITS-1]}}, e};
    endfunction

    function automatic t_err sat_err(input t_val v);
        t_err r;
        if (v > ERR_HI) begin
            r = ERR_HI[ERROR_BITS-1:0];
        end else if (v < ERR_LO) begin
            r = ERR_LO[ERROR_BITS-1:0];
        end else begin
            r = v[ERROR_BITS-1:0];
        end
        return r;
    endfunction

    // e * k / 16, truncated toward zero
    function automatic t_err share(input t_err e, input logic [2:0] k);
        logic signed [ERROR_BITS+3:0] p;
        logic signed [ERROR_BITS+3:0] q;
        p = $signed({{4{e[ERROR_BITS-1]}}, e}) * $signed({1'b0, k});
        if (p < 0) begin
            q = (p + $signed((ERROR_BITS + 4)'(15))) >>> 4;
        end else begin
            q = p >>> 4;
        end
        return q[ERROR_BITS-1:0];
    endfunction

    function automatic logic [CH_BITS-1:0] gray_of(input logic [SUM_BITS-1:0] sum);
        logic [PROD_BITS-1:0] prod;
        prod = PROD_BITS'(sum) * PROD_BITS'(DIV3_MUL);
        return prod[DIV3_SHIFT +: CH_BITS];
    endfunction

endpackage

`default_nettype wire

// File: rtl/edd_if.sv
// edd_if: valid/ready stream interfaces for pixel beats in and dither result beats out
// depends on edd_pkg
`default_nettype none

interface edd_pix_if;
    logic                        valid;
    logic                        ready;
    logic [edd_pkg::CH_BITS-1:0] red;
    logic [edd_pkg::CH_BITS-1:0] green;
    logic [edd_pkg::CH_BITS-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface edd_res_if;
    logic valid;
    logic ready;
    logic white;
    logic end_of_row;
    logic end_of_frame;

    modport source (output valid, output white, output end_of_row, output end_of_frame,
                    input ready);
    modport sink   (input valid, input white, input end_of_row, input end_of_frame,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/edd_diffuse.sv
// edd_diffuse: quantise one corrected gray value and split its error to the neighbours
// depends on edd_pkg
`default_nettype none

module edd_diffuse (
    input  edd_pkg::t_diff_in  i_d,
    output edd_pkg::t_diff_out o_d
);

    edd_pkg::t_val v;
    edd_pkg::t_val v_q;
    edd_pkg::t_val thr;
    edd_pkg::t_err e;
    edd_pkg::t_err pbl_next;
    logic          white;

    assign v = edd_pkg::VAL_BITS'(i_d.gray) + edd_pkg::ext_err(i_d.right)
             + edd_pkg::ext_err(i_d.below);
    assign thr   = edd_pkg::VAL_BITS'(i_d.threshold);
    assign white = v > thr;
    assign v_q   = white ? v - edd_pkg::WHITE_LEVEL : v;
    assign e     = edd_pkg::sat_err(v_q);

    assign pbl_next = edd_pkg::sat_err(edd_pkg::ext_err(i_d.pend_below)
                    + edd_pkg::ext_err(edd_pkg::share(e, edd_pkg::WEIGHT_BELOW)));

    always_comb begin
        o_d.white     = white;
        o_d.row_write = edd_pkg::sat_err(edd_pkg::ext_err(i_d.pend_below_left)
                      + edd_pkg::ext_err(edd_pkg::share(e, edd_pkg::WEIGHT_BELOW_LEFT)));
        o_d.tail      = pbl_next;
        if (i_d.last_col) begin
            o_d.pend_below_left = '0;
            o_d.pend_below      = '0;
            o_d.right           = '0;
        end else begin
            o_d.pend_below_left = pbl_next;
            o_d.pend_below      = edd_pkg::share(e, edd_pkg::WEIGHT_BELOW_RGT);
            o_d.right           = edd_pkg::share(e, edd_pkg::WEIGHT_RIGHT);
        end
    end

endmodule

`default_nettype wire

// File: rtl/error_diffusion_dither_core.sv
// error_diffusion_dither_core: 1-bit error diffusion dither of a raster-order rgb stream
// depends on edd_pkg, edd_if (edd_pix_if, edd_res_if) and edd_diffuse
`default_nettype none

// Takes one rgb pixel beat per clock in raster order while the output is not stalled and
// returns one result beat per pixel (white or black, plus end-of-row and end-of-frame flags)
// in the same order. Throughput is one pixel per clock when the output is not stalled, set
// by the right-neighbour error loop, which is closed in a single stage: add, threshold
// compare, saturate and weight all in that stage. A result passes from the working stage
// to the output register, and the stage holds while a stalled output register is full.
// The next row's errors sit in a line buffer of MAX_WIDTH entries, read when a pixel is
// accepted and written when it leaves the stage, with forwarding around both. The buffer
// is not cleared after reset; the first row of every frame does not use it, so no
// clearing pass is needed. Configuration (width, height, threshold) is a plain write port
// and must only be written while the block is idle. Out-of-range width or height is
// clamped to 1 or the maximum.

module error_diffusion_dither_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [edd_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [edd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    edd_pix_if.sink                           i_pix,
    edd_res_if.source                         o_res
);

    // configuration registers
    logic [edd_pkg::CFG_W_BITS-1:0] r_cfg_width;
    logic [edd_pkg::CFG_H_BITS-1:0] r_cfg_height;
    logic [edd_pkg::THR_BITS-1:0]   r_cfg_thr;

    // raster position of the next pixel to be accepted
    logic [edd_pkg::COL_BITS-1:0] r_col;
    logic [edd_pkg::ROW_BITS-1:0] r_row;

    // clamped last column / last row
    logic [edd_pkg::COL_BITS-1:0] w_last;
    logic [edd_pkg::ROW_BITS-1:0] h_last;

    // accept side
    logic                         in_acc;
    logic                         acc_last_col;
    logic                         acc_last_row;
    logic [edd_pkg::COL_BITS-1:0] acc_x;
    logic [edd_pkg::COL_BITS-1:0] n_col;
    logic [edd_pkg::ROW_BITS-1:0] n_row;
    logic [edd_pkg::SUM_BITS-1:0] rgb_sum;

    // working stage
    logic                         r_s_valid;
    logic [edd_pkg::CH_BITS-1:0]  r_s_gray;
    logic [edd_pkg::COL_BITS-1:0] r_s_x;
    logic                         r_s_last_col;
    logic                         r_s_last_row;
    logic                         r_s_top;
    logic                         s_fire;

    // line buffer and its forwarding
    edd_pkg::t_err                r_line [edd_pkg::MAX_WIDTH];
    edd_pkg::t_err                r_rd;
    logic                         r_byp_hit;
    edd_pkg::t_err                r_byp_data;
    logic                         mem_we;
    logic [edd_pkg::COL_BITS-1:0] mem_waddr;
    edd_pkg::t_err                mem_wdata;

    // entry for the last column of a row, held until the next pixel frees the write port
    logic                         r_tail_valid;
    logic [edd_pkg::COL_BITS-1:0] r_tail_addr;
    edd_pkg::t_err                r_tail_data;
    logic                         tail_hit;

    // diffusion state
    edd_pkg::t_err r_right;
    edd_pkg::t_err r_pb;
    edd_pkg::t_err r_pbl;
    edd_pkg::t_err below;

    edd_pkg::t_diff_in  d_in;
    edd_pkg::t_diff_out d_out;

    // output register
    logic r_o_valid;
    logic r_o_white;
    logic r_o_eor;
    logic r_o_eof;

    // width 0 acts as 1, anything above the buffer depth acts as the depth
    always_comb begin
        if (r_cfg_width == '0) begin
            w_last = '0;
        end else if (32'(r_cfg_width) > edd_pkg::MAX_WIDTH) begin
            w_last = edd_pkg::COL_BITS'(edd_pkg::MAX_WIDTH - 1);
        end else begin
            w_last = edd_pkg::COL_BITS'(32'(r_cfg_width) - 32'd1);
        end
        if (r_cfg_height == '0) begin
            h_last = '0;
        end else if (32'(r_cfg_height) > edd_pkg::MAX_HEIGHT) begin
            h_last = edd_pkg::ROW_BITS'(edd_pkg::MAX_HEIGHT - 1);
        end else begin
            h_last = edd_pkg::ROW_BITS'(32'(r_cfg_height) - 32'd1);
        end
    end

    // position bookkeeping runs at accept time, it never depends on pixel data
    // a count at or past the last column (after a width change) ends the row at once
    assign acc_last_col = r_col >= w_last;
    assign acc_last_row = r_row >= h_last;
    assign acc_x        = acc_last_col ? w_last : r_col;
    assign n_col        = acc_last_col ? '0 : acc_x + 1'b1;
    assign n_row        = acc_last_row ? '0 : r_row + 1'b1;

    assign rgb_sum = edd_pkg::SUM_BITS'(i_pix.red) + edd_pkg::SUM_BITS'(i_pix.green)
                   + edd_pkg::SUM_BITS'(i_pix.blue);

    // stage moves on whenever the output register is free or being drained
    assign s_fire      = r_s_valid && (!r_o_valid || o_res.ready);
    assign i_pix.ready = !r_s_valid || s_fire;
    assign in_acc      = i_pix.valid && i_pix.ready;

    // newest source of the error from above wins: tail, then same-edge write, then buffer
    assign tail_hit = r_tail_valid && (r_tail_addr == r_s_x);

    always_comb begin
        if (r_s_top) begin
            below = '0;
        end else if (tail_hit) begin
            below = r_tail_data;
        end else if (r_byp_hit) begin
            below = r_byp_data;
        end else begin
            below = r_rd;
        end
    end

    always_comb begin
        d_in.gray            = r_s_gray;
        d_in.threshold       = r_cfg_thr;
        d_in.right           = r_right;
        d_in.below           = below;
        d_in.pend_below      = r_pb;
        d_in.pend_below_left = r_pbl;
        d_in.last_col        = r_s_last_col;
    end

    edd_diffuse u_diffuse (
        .i_d (d_in),
        .o_d (d_out)
    );

    // each pixel after the first of a row closes the below-left entry; the first pixel of a row flushes the tail
    assign mem_we    = s_fire && ((r_s_x != '0) || r_tail_valid);
    assign mem_waddr = (r_s_x != '0) ? r_s_x - 1'b1 : r_tail_addr;
    assign mem_wdata = (r_s_x != '0) ? d_out.row_write : r_tail_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_line[mem_waddr] <= mem_wdata;
        end
        if (in_acc) begin
            r_rd <= r_line[acc_x];
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s_gray     <= edd_pkg::gray_of(rgb_sum);
            r_s_x        <= acc_x;
            r_s_last_col <= acc_last_col;
            r_s_last_row <= acc_last_row;
            r_s_top      <= (r_row == '0);
            r_byp_data   <= mem_wdata;
        end
        if (s_fire) begin
            r_o_white <= d_out.white;
            r_o_eor   <= r_s_last_col;
            r_o_eof   <= r_s_last_col && r_s_last_row;
            if (r_s_last_col) begin
                r_tail_addr <= r_s_x;
                r_tail_data <= d_out.tail;
            end
        end
    end

    // control and diffusion state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= edd_pkg::WIDTH_RESET;
            r_cfg_height <= edd_pkg::HEIGHT_RESET;
            r_cfg_thr    <= edd_pkg::THR_RESET;
            r_col        <= '0;
            r_row        <= '0;
            r_s_valid    <= 1'b0;
            r_byp_hit    <= 1'b0;
            r_tail_valid <= 1'b0;
            r_right      <= '0;
            r_pb         <= '0;
            r_pbl        <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    edd_pkg::CFG_IMAGE_WIDTH: begin
                        r_cfg_width <= i_cfg_data[edd_pkg::CFG_W_BITS-1:0];
                    end
                    edd_pkg::CFG_IMAGE_HEIGHT: begin
                        r_cfg_height <= i_cfg_data[edd_pkg::CFG_H_BITS-1:0];
                    end
                    edd_pkg::CFG_WHITE_THRESHOLD: begin
                        r_cfg_thr <= i_cfg_data[edd_pkg::THR_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (in_acc) begin
                r_col     <= n_col;
                if (acc_last_col) begin
                    r_row <= n_row;
                end
                r_s_valid <= 1'b1;
                // buffer read misses a write landing on the same entry at this edge
                r_byp_hit <= mem_we && (mem_waddr == acc_x);
            end else if (s_fire) begin
                r_s_valid <= 1'b0;
            end

            if (s_fire) begin
                r_right <= d_out.right;
                r_pb    <= d_out.pend_below;
                r_pbl   <= d_out.pend_below_left;
                if (r_s_last_col) begin
                    r_tail_valid <= 1'b1;
                end else if (r_s_x == '0) begin
                    r_tail_valid <= 1'b0;
                end
            end

            if (s_fire) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid        = r_o_valid;
    assign o_res.white        = r_o_white;
    assign o_res.end_of_row   = r_o_eor;
    assign o_res.end_of_frame = r_o_eof;

`ifndef NO_ASSERTIONS
    // a pending tail always belongs to the row just finished, so the pixel behind it opens a row
    a_tail_then_col0 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail_valid && r_s_valid |-> r_s_x == '0)
        else $error("tail entry pending while stage holds a mid-row pixel");

    // no error crosses the right edge into the next row
    a_row_end_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && r_s_last_col |=> r_right == '0 && r_pb == '0 && r_pbl == '0)
        else $error("diffusion state not cleared at end of row");

    // end of frame is only flagged on a row end
    a_eof_on_eor : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_eof |-> r_o_eor)
        else $error("end of frame without end of row");
`endif

endmodule

`default_nettype wire
